>>> rtl/crr_pkg.sv
// ----------------------------------------------------------------------------
// crr_pkg
// Shared types and constants for the CAN transport receive reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package crr_pkg;

  // default reassembly buffer size in bytes
  localparam int BUFFER_BYTES_DEF = 64;

  // fixed field widths
  localparam int IDX_W   = 6;   // byte_index
  localparam int MLEN_W  = 7;   // msg_length
  localparam int TOTAL_W = 12;  // first-frame length field

  // protocol control nibbles
  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  // flow-control first bytes
  localparam logic [7:0] FC_CONTINUE = 8'h30;
  localparam logic [7:0] FC_OVERFLOW = 8'h32;

  // payload limits per frame type
  localparam logic [2:0] FF_DATA_BYTES = 3'd6;
  localparam logic [2:0] CF_DATA_BYTES = 3'd7;
  localparam logic [3:0] SF_MAX_LEN    = 4'd7;

  // offset of the first data byte within a frame
  localparam logic [2:0] SF_CF_OFFSET = 3'd1;
  localparam logic [2:0] FF_OFFSET    = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_FLOW,
    ST_SF,
    ST_RD,
    ST_DRAIN
  } state_t;

  // one result word, handed from the sequencer to the output register
  typedef struct packed {
    logic              kind;
    logic [7:0]        flow_byte;
    logic [7:0]        msg_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [MLEN_W-1:0] msg_length;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/crr_store.sv
// ----------------------------------------------------------------------------
// crr_store
// Message buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module crr_store #(
  parameter int BUFFER_BYTES = crr_pkg::BUFFER_BYTES_DEF,
  parameter int ADDR_W       = $clog2(BUFFER_BYTES)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [7:0]        rd_data
);

  logic [7:0] mem [BUFFER_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/crr_seq.sv
// ----------------------------------------------------------------------------
// crr_seq
// Frame classifier and sequencer: captures a frame, writes its data bytes
// into the buffer one per cycle, drives results one per cycle when res_free.
// ----------------------------------------------------------------------------
`default_nettype none

module crr_seq #(
  parameter int BUFFER_BYTES = crr_pkg::BUFFER_BYTES_DEF,
  parameter int ADDR_W       = $clog2(BUFFER_BYTES),
  parameter int LEN_W        = $clog2(BUFFER_BYTES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [3:0]        frame_len,
  input  wire logic [7:0]        byte_0,
  input  wire logic [7:0]        byte_1,
  input  wire logic [7:0]        byte_2,
  input  wire logic [7:0]        byte_3,
  input  wire logic [7:0]        byte_4,
  input  wire logic [7:0]        byte_5,
  input  wire logic [7:0]        byte_6,
  input  wire logic [7:0]        byte_7,
  input  wire logic              res_free,
  output      logic              res_load,
  output      crr_pkg::res_t     res,
  output      logic              wr_en,
  output      logic [ADDR_W-1:0] wr_addr,
  output      logic [7:0]        wr_data,
  output      logic              rd_en,
  output      logic [ADDR_W-1:0] rd_addr,
  input  wire logic [7:0]        rd_data
);

  crr_pkg::state_t state, state_next;

  logic [7:0]       frame [8];
  logic             receiving;
  logic [3:0]       exp_seq;
  logic [LEN_W-1:0] fill;
  logic [LEN_W-1:0] msg_len;
  logic [LEN_W-1:0] cnt;
  logic [2:0]       k;
  logic [2:0]       base;
  logic [2:0]       lim;
  logic [2:0]       sf_len;
  logic             is_ff;
  logic [7:0]       flow;

  logic [3:0]                  pci;
  logic [3:0]                  low;
  logic [crr_pkg::TOTAL_W-1:0] total;
  logic                        ff_ok;
  logic                        go;
  logic                        wr_go;
  logic                        done;
  logic [2:0]                  k_inc;
  logic [2:0]                  frame_sel;
  logic [LEN_W-1:0]            cnt_inc;
  logic                        sf_last;
  logic                        drain_last;

  assign pci       = byte_0[7:4];
  assign low       = byte_0[3:0];
  assign total     = {low, byte_1};
  assign ff_ok     = total <= crr_pkg::TOTAL_W'(BUFFER_BYTES);
  assign in_stall  = state != crr_pkg::ST_IDLE;
  assign go        = in_valid && !in_stall && frame_len != 4'd0;
  assign done      = fill >= msg_len;
  assign wr_go     = k < lim && !done;
  assign k_inc     = k + 3'd1;
  assign frame_sel = base + k;
  assign cnt_inc   = cnt + LEN_W'(1);
  assign sf_last   = k_inc == sf_len;
  assign drain_last = cnt_inc == msg_len;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      crr_pkg::ST_IDLE: begin
        if (go) begin
          unique case (pci)
            crr_pkg::PCI_SF: begin
              if (low != 4'd0 && low <= crr_pkg::SF_MAX_LEN) begin
                state_next = crr_pkg::ST_SF;
              end
            end
            crr_pkg::PCI_FF: begin
              state_next = ff_ok ? crr_pkg::ST_WRITE : crr_pkg::ST_FLOW;
            end
            crr_pkg::PCI_CF: begin
              if (receiving && low == exp_seq) begin
                state_next = crr_pkg::ST_WRITE;
              end
            end
            default: state_next = crr_pkg::ST_IDLE;
          endcase
        end
      end
      crr_pkg::ST_WRITE: begin
        if (!wr_go) begin
          if (is_ff) begin
            state_next = crr_pkg::ST_FLOW;
          end else if (done && msg_len != '0) begin
            state_next = crr_pkg::ST_RD;
          end else begin
            state_next = crr_pkg::ST_IDLE;
          end
        end
      end
      crr_pkg::ST_FLOW: begin
        if (res_free) begin
          state_next = crr_pkg::ST_IDLE;
        end
      end
      crr_pkg::ST_SF: begin
        if (res_free && sf_last) begin
          state_next = crr_pkg::ST_IDLE;
        end
      end
      crr_pkg::ST_RD: begin
        state_next = crr_pkg::ST_DRAIN;
      end
      crr_pkg::ST_DRAIN: begin
        if (res_free && drain_last) begin
          state_next = crr_pkg::ST_IDLE;
        end
      end
      default: state_next = crr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = fill[ADDR_W-1:0];
    wr_data  = frame[frame_sel];
    rd_en    = 1'b0;
    rd_addr  = cnt_inc[ADDR_W-1:0];
    res_load = 1'b0;
    res      = '0;
    unique case (state)
      crr_pkg::ST_IDLE: begin
      end
      crr_pkg::ST_WRITE: begin
        wr_en = wr_go;
      end
      crr_pkg::ST_FLOW: begin
        res_load      = res_free;
        res.kind      = 1'b0;
        res.flow_byte = flow;
        res.last      = 1'b1;
      end
      crr_pkg::ST_SF: begin
        res_load       = res_free;
        res.kind       = 1'b1;
        res.msg_byte   = frame[frame_sel];
        res.byte_index = crr_pkg::IDX_W'(k);
        res.msg_length = crr_pkg::MLEN_W'(sf_len);
        res.last       = sf_last;
      end
      crr_pkg::ST_RD: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      crr_pkg::ST_DRAIN: begin
        res_load       = res_free;
        rd_en          = res_free && !drain_last;
        res.kind       = 1'b1;
        res.msg_byte   = rd_data;
        res.byte_index = crr_pkg::IDX_W'(cnt);
        res.msg_length = crr_pkg::MLEN_W'(msg_len);
        res.last       = drain_last;
      end
      default: begin
      end
    endcase
  end

  // captured frame: all eight bytes, PCI byte included
  always_ff @(posedge clk) begin
    if (go) begin
      frame[0] <= byte_0;
      frame[1] <= byte_1;
      frame[2] <= byte_2;
      frame[3] <= byte_3;
      frame[4] <= byte_4;
      frame[5] <= byte_5;
      frame[6] <= byte_6;
      frame[7] <= byte_7;
      sf_len   <= low[2:0];
      flow     <= ff_ok ? crr_pkg::FC_CONTINUE : crr_pkg::FC_OVERFLOW;
    end
  end

  // control and reassembly state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= crr_pkg::ST_IDLE;
      receiving <= 1'b0;
      exp_seq   <= '0;
      fill      <= '0;
      msg_len   <= '0;
      cnt       <= '0;
      k         <= '0;
      base      <= crr_pkg::SF_CF_OFFSET;
      lim       <= crr_pkg::CF_DATA_BYTES;
      is_ff     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        crr_pkg::ST_IDLE: begin
          if (go) begin
            k   <= '0;
            cnt <= '0;
            if (pci == crr_pkg::PCI_FF && ff_ok) begin
              msg_len   <= total[LEN_W-1:0];
              fill      <= '0;
              exp_seq   <= 4'd1;
              receiving <= 1'b1;
              is_ff     <= 1'b1;
              base      <= crr_pkg::FF_OFFSET;
              lim       <= crr_pkg::FF_DATA_BYTES;
            end else begin
              is_ff <= 1'b0;
              base  <= crr_pkg::SF_CF_OFFSET;
              lim   <= crr_pkg::CF_DATA_BYTES;
              if (pci == crr_pkg::PCI_CF && receiving) begin
                if (low != exp_seq) begin
                  receiving <= 1'b0;
                end else begin
                  exp_seq <= exp_seq + 4'd1;  // wraps 15 to 0
                end
              end
            end
          end
        end
        crr_pkg::ST_WRITE: begin
          if (wr_go) begin
            fill <= fill + LEN_W'(1);
            k    <= k_inc;
          end else if (!is_ff && done) begin
            receiving <= 1'b0;
          end
        end
        crr_pkg::ST_SF: begin
          if (res_free) begin
            k <= k_inc;
          end
        end
        crr_pkg::ST_DRAIN: begin
          if (res_free) begin
            cnt <= cnt_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/can_transport_receive_reassembler.sv
// ----------------------------------------------------------------------------
// can_transport_receive_reassembler
// Receive side of a CAN transport layer: single, first and consecutive
// frames in, flow-control words and reassembled message bytes out.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  frame   | in_valid / in_stall   | frame_len, byte_0 .. byte_7
//  result  | out_valid / out_stall | kind, flow_byte, msg_byte, byte_index,
//          |                       | msg_length, last
//
//  Flow: a single frame of length n gives n words, a word a cycle while
//  the output register is free. A first frame writes up to 6 bytes into
//  the buffer at one byte a cycle, then gives its flow-control word. A
//  consecutive frame writes up to 7 bytes; the one that completes a message
//  then passes through a read state and gives a byte a cycle from the
//  buffer's single read port while the output register is free. A full
//  64-byte message ends with a consecutive frame that carries two bytes.
//  The sequencer writes one byte per cycle through the buffer's write port.
//  Reset: clears the sequencer and reassembly state; the buffer needs no
//  clearing pass, as only bytes written in the current message are read.
//  Stalls: out_stall holds the output register; the sequencer waits behind
//  it. A new frame is taken only while the sequencer is idle, even if a
//  final word is still waiting in the output register.
//
`default_nettype none

module can_transport_receive_reassembler #(
  parameter int BUFFER_BYTES = crr_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // frame channel
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic [3:0]                 frame_len,
  input  wire logic [7:0]                 byte_0,
  input  wire logic [7:0]                 byte_1,
  input  wire logic [7:0]                 byte_2,
  input  wire logic [7:0]                 byte_3,
  input  wire logic [7:0]                 byte_4,
  input  wire logic [7:0]                 byte_5,
  input  wire logic [7:0]                 byte_6,
  input  wire logic [7:0]                 byte_7,
  // result channel
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic                       kind,
  output      logic [7:0]                 flow_byte,
  output      logic [7:0]                 msg_byte,
  output      logic [crr_pkg::IDX_W-1:0]  byte_index,
  output      logic [crr_pkg::MLEN_W-1:0] msg_length,
  output      logic                       last
);

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int LEN_W  = $clog2(BUFFER_BYTES + 1);

  logic              res_free;
  logic              res_load;
  crr_pkg::res_t     res;
  crr_pkg::res_t     out_word;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  // output register may load when empty or being taken this cycle
  assign res_free = !out_valid || !out_stall;

  crr_seq #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .ADDR_W       (ADDR_W),
    .LEN_W        (LEN_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .frame_len (frame_len),
    .byte_0    (byte_0),
    .byte_1    (byte_1),
    .byte_2    (byte_2),
    .byte_3    (byte_3),
    .byte_4    (byte_4),
    .byte_5    (byte_5),
    .byte_6    (byte_6),
    .byte_7    (byte_7),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  crr_store #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .ADDR_W       (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: valid under reset, payload not
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_word <= res;
    end
  end

  assign kind       = out_word.kind;
  assign flow_byte  = out_word.flow_byte;
  assign msg_byte   = out_word.msg_byte;
  assign byte_index = out_word.byte_index;
  assign msg_length = out_word.msg_length;
  assign last       = out_word.last;

endmodule

`default_nettype wire

>>> rtl/crr_check.sv
// ----------------------------------------------------------------------------
// crr_check
// Port-level checks on the reassembler's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module crr_check (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic                       kind,
  input wire logic [7:0]                 flow_byte,
  input wire logic [7:0]                 msg_byte,
  input wire logic [crr_pkg::IDX_W-1:0]  byte_index,
  input wire logic [crr_pkg::MLEN_W-1:0] msg_length,
  input wire logic                       last
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(flow_byte)
      && $stable(msg_byte) && $stable(byte_index) && $stable(msg_length)
      && $stable(last))
    else $error("result word changed under stall");

  // flow-control words are single and carry only a known code
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> last && msg_byte == 8'd0 && byte_index == '0
      && msg_length == '0
      && (flow_byte == crr_pkg::FC_CONTINUE || flow_byte == crr_pkg::FC_OVERFLOW))
    else $error("malformed flow-control word");

  // message bytes follow one another with no gap and rising index
  a_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && kind && !last |=> out_valid && kind
      && byte_index == crr_pkg::IDX_W'($past(byte_index) + 1'b1)
      && msg_length == $past(msg_length) && flow_byte == 8'd0)
    else $error("message byte run broken");

  // nothing is shown right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind can_transport_receive_reassembler crr_check u_crr_check (.*);

`default_nettype wire

>>> tb/can_transport_receive_reassembler_tb.sv
// ----------------------------------------------------------------------------
// can_transport_receive_reassembler_tb
// Self-checking bench for the CAN transport receive reassembler. Frames are
// queued up front: a directed opening (ignored frames, single-frame limits,
// overflow, zero-length and short messages, sequence errors, a full 64-byte
// message with foreign frames mixed in), then random traffic that is mostly
// complete first/consecutive sequences with random content. A local
// reassembly model predicts every result word; the monitor compares each
// accepted word field by field against the oldest prediction. Both channels
// idle and stall at random, apart from one calm stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module can_transport_receive_reassembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         TOTAL_FRAMES  = 230;    // frames queued, directed ones included
  localparam int         IDLE_PCT      = 28;     // chance of a gap or stall per cycle
  localparam int         STALL_LIMIT   = 4000;   // cycles with no word moving
  localparam int         DRAIN_CYCLES  = 200;    // settle time after the last word
  localparam logic [3:0] PCI_FLOW      = 4'h3;   // flow-control frames: no effect on rx
  localparam logic [3:0] SEQ_LAST      = 4'hF;   // sequence nibble wraps after this

  // one CAN frame as presented on the input channel; data[0] is byte_0
  typedef struct packed {
    logic [3:0]      len;
    logic [7:0][7:0] data;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [3:0] frame_len = '0;
  logic [7:0] byte_0    = '0;
  logic [7:0] byte_1    = '0;
  logic [7:0] byte_2    = '0;
  logic [7:0] byte_3    = '0;
  logic [7:0] byte_4    = '0;
  logic [7:0] byte_5    = '0;
  logic [7:0] byte_6    = '0;
  logic [7:0] byte_7    = '0;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       kind;
  logic [7:0]                 flow_byte;
  logic [7:0]                 msg_byte;
  logic [crr_pkg::IDX_W-1:0]  byte_index;
  logic [crr_pkg::MLEN_W-1:0] msg_length;
  logic                       last;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  can_transport_receive_reassembler u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .frame_len  (frame_len),
    .byte_0     (byte_0),
    .byte_1     (byte_1),
    .byte_2     (byte_2),
    .byte_3     (byte_3),
    .byte_4     (byte_4),
    .byte_5     (byte_5),
    .byte_6     (byte_6),
    .byte_7     (byte_7),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .flow_byte  (flow_byte),
    .msg_byte   (msg_byte),
    .byte_index (byte_index),
    .msg_length (msg_length),
    .last       (last)
  );

  // --------------------------------------------------------------------------
  // Reassembly model: own copy of the receive state
  // --------------------------------------------------------------------------
  frame_t          frames_pending[$];     // stimulus not yet offered
  crr_pkg::res_t   expected_words[$];     // predicted result words, oldest first
  bit              rx_active = 1'b0;
  logic [3:0]      rx_seq    = 4'd0;
  int              rx_fill   = 0;
  int              rx_len    = 0;
  logic [7:0]      rx_store [crr_pkg::BUFFER_BYTES_DEF];

  int frames_taken   = 0;
  int live_frames    = 0;  // queued frames that the block actually acts on
  int errors         = 0;
  int words_checked  = 0;
  int msgs_done      = 0;
  int flow_words     = 0;
  int overflow_words = 0;
  int quiet_cycles   = 0;

  // calm stretch: neither side idles while these frames go through
  logic calm;
  assign calm = (frames_taken >= 60 && frames_taken < 120);

  function automatic void push_word(input logic fc_or_data, input logic [7:0] fc,
                                    input logic [7:0] data, input int idx,
                                    input int mlen, input bit fin);
    crr_pkg::res_t w;
    w.kind       = fc_or_data;
    w.flow_byte  = fc;
    w.msg_byte   = data;
    w.byte_index = crr_pkg::IDX_W'(idx);
    w.msg_length = crr_pkg::MLEN_W'(mlen);
    w.last       = fin;
    expected_words.push_back(w);
  endfunction

  task automatic reassemble_frame(input frame_t f);
    logic [3:0] pci;
    logic [3:0] low;
    int         total;
    if (f.len == 4'd0) return;  // empty frame: dropped before decode
    pci = f.data[0][7:4];
    low = f.data[0][3:0];
    case (pci)
      crr_pkg::PCI_SF: begin
        // single frame: payload straight out, reassembly untouched
        if (low >= 4'd1 && low <= crr_pkg::SF_MAX_LEN)
          for (int k = 0; k < low; k++)
            push_word(1'b1, 8'h00, f.data[k + 1], k, low, k + 1 == low);
      end
      crr_pkg::PCI_FF: begin
        total = {low, f.data[1]};
        if (total > crr_pkg::BUFFER_BYTES_DEF) begin
          push_word(1'b0, crr_pkg::FC_OVERFLOW, 8'h00, 0, 0, 1'b1);
        end else begin
          rx_len  = total;
          rx_fill = 0;
          rx_seq  = 4'd1;
          for (int k = 0; k < crr_pkg::FF_DATA_BYTES && rx_fill < total; k++) begin
            rx_store[rx_fill] = f.data[k + 2];
            rx_fill++;
          end
          rx_active = 1'b1;
          push_word(1'b0, crr_pkg::FC_CONTINUE, 8'h00, 0, 0, 1'b1);
        end
      end
      crr_pkg::PCI_CF: begin
        if (!rx_active) begin
          // nothing open: ignored
        end else if (low != rx_seq) begin
          rx_active = 1'b0;  // sequence error drops the message silently
        end else begin
          for (int k = 0; k < crr_pkg::CF_DATA_BYTES && rx_fill < rx_len
               && rx_fill < crr_pkg::BUFFER_BYTES_DEF; k++) begin
            rx_store[rx_fill] = f.data[k + 1];
            rx_fill++;
          end
          rx_seq = (rx_seq == SEQ_LAST) ? 4'd0 : rx_seq + 4'd1;
          if (rx_fill >= rx_len) begin
            rx_active = 1'b0;
            // zero-length message completes with no words at all
            for (int k = 0; k < rx_len; k++)
              push_word(1'b1, 8'h00, rx_store[k], k, rx_len, k + 1 == rx_len);
          end
        end
      end
      default: ;  // flow control and unknown PCI: no effect
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [3:0] pick_len();
    // mostly a real 8-byte frame; sometimes any non-zero count, 9..15 included
    return ($urandom_range(3) == 0) ? 4'($urandom_range(1, 15)) : 4'd8;
  endfunction

  task automatic queue_frame(input logic [3:0] len, input logic [7:0] b0,
                             input logic [7:0] b1, input bit counts);
    frame_t f;
    f.len = len;
    for (int k = 2; k < 8; k++) f.data[k] = 8'($urandom);
    f.data[0] = b0;
    f.data[1] = b1;
    frames_pending.push_back(f);
    if (counts) live_frames++;
  endtask

  // frames that must leave an open reassembly undisturbed
  task automatic queue_noise();
    int         pick;
    int         big;
    logic [3:0] low;
    pick = $urandom_range(3);
    low  = 4'($urandom);
    case (pick)
      0: queue_frame(pick_len(), {crr_pkg::PCI_SF, low}, 8'($urandom),
                     low >= 4'd1 && low <= crr_pkg::SF_MAX_LEN);
      1: begin
        big = $urandom_range(crr_pkg::BUFFER_BYTES_DEF + 1, (1 << crr_pkg::TOTAL_W) - 1);
        queue_frame(pick_len(), {crr_pkg::PCI_FF, 4'(big >> 8)}, 8'(big), 1'b1);
      end
      2: queue_frame(pick_len(), {4'($urandom_range(PCI_FLOW, 15)), low},
                     8'($urandom), 1'b0);
      default: queue_frame(4'd0, 8'($urandom), 8'($urandom), 1'b0);
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued frames, holds a frame steady while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_frames
    frame_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (frames_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt       = frames_pending.pop_front();
        in_valid  <= 1'b1;
        frame_len <= nxt.len;
        byte_0    <= nxt.data[0];
        byte_1    <= nxt.data[1];
        byte_2    <= nxt.data[2];
        byte_3    <= nxt.data[3];
        byte_4    <= nxt.data[4];
        byte_5    <= nxt.data[5];
        byte_6    <= nxt.data[6];
        byte_7    <= nxt.data[7];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts from the frame taken off the input ports, then checks
  // the result word taken at the same edge (never caused by that frame, as
  // the output is registered)
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_words
    frame_t        seen;
    crr_pkg::res_t got;
    crr_pkg::res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        seen.len  = frame_len;
        seen.data = {byte_7, byte_6, byte_5, byte_4, byte_3, byte_2, byte_1, byte_0};
        reassemble_frame(seen);
        frames_taken <= frames_taken + 1;
      end
      if (out_valid && !out_stall) begin
        got.kind       = kind;
        got.flow_byte  = flow_byte;
        got.msg_byte   = msg_byte;
        got.byte_index = byte_index;
        got.msg_length = msg_length;
        got.last       = last;
        words_checked++;
        if (!kind) flow_words++;
        if (!kind && flow_byte == crr_pkg::FC_OVERFLOW) overflow_words++;
        if (kind && last) msgs_done++;
        if (expected_words.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected word kind=%0d flow=%h byte=%h idx=%0d len=%0d last=%0d",
                     $realtime, kind, flow_byte, msg_byte, byte_index, msg_length, last);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (got.kind !== want.kind || got.flow_byte !== want.flow_byte
              || got.msg_byte !== want.msg_byte || got.byte_index !== want.byte_index
              || got.msg_length !== want.msg_length || got.last !== want.last) begin
            if (errors < 10) begin
              $display("%0t: word mismatch", $realtime);
              $display("  exp kind=%0d flow=%h byte=%h idx=%0d len=%0d last=%0d",
                       want.kind, want.flow_byte, want.msg_byte, want.byte_index,
                       want.msg_length, want.last);
              $display("  got kind=%0d flow=%h byte=%h idx=%0d len=%0d last=%0d",
                       got.kind, got.flow_byte, got.msg_byte, got.byte_index,
                       got.msg_length, got.last);
            end
            errors++;
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog: nothing moving on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d predictions open",
               STALL_LIMIT, expected_words.size());
      $display("can_transport_receive_reassembler_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : run
    frame_t ones;
    int     roll;
    int     sel;
    int     total;
    int     ncf;
    logic [3:0] low;

    // directed opening
    queue_frame(4'd0, {crr_pkg::PCI_SF, 4'd3}, 8'h11, 1'b0);   // zero frame length
    ones.len  = 4'd15;                                         // over-long count, all ones
    ones.data = '1;
    ones.data[0] = {crr_pkg::PCI_SF, crr_pkg::SF_MAX_LEN};
    frames_pending.push_back(ones);
    queue_frame(4'd1, {crr_pkg::PCI_SF, 4'd1}, 8'h00, 1'b1);   // shortest single frame
    queue_frame(4'd8, {crr_pkg::PCI_SF, 4'd0}, 8'h5A, 1'b0);   // SF length 0
    queue_frame(4'd8, {crr_pkg::PCI_SF, 4'd8}, 8'h5A, 1'b0);   // SF length 8
    queue_frame(4'd8, {crr_pkg::PCI_FF, 4'hF}, 8'hFF, 1'b1);   // 4095 bytes: overflow
    queue_frame(4'd8, {crr_pkg::PCI_FF, 4'h0},
                8'(crr_pkg::BUFFER_BYTES_DEF + 1), 1'b1);      // one over
    queue_frame(4'd8, {crr_pkg::PCI_CF, 4'd1}, 8'h77, 1'b0);   // CF with nothing open
    queue_frame(4'd8, {PCI_FLOW, 4'h0}, 8'h00, 1'b0);          // flow control in
    queue_frame(4'd8, {crr_pkg::PCI_FF, 4'h0}, 8'd0, 1'b1);    // zero-length message
    queue_frame(4'd8, {crr_pkg::PCI_CF, 4'd1}, 8'h00, 1'b1);
    queue_frame(4'd8, {crr_pkg::PCI_FF, 4'h0}, 8'd3, 1'b1);    // short FF waits for a CF
    queue_frame(4'd8, {crr_pkg::PCI_CF, 4'd1}, 8'hA5, 1'b1);
    queue_frame(4'd8, {crr_pkg::PCI_FF, 4'h0}, 8'd20, 1'b1);   // sequence error aborts
    queue_frame(4'd8, {crr_pkg::PCI_CF, 4'd2}, 8'h3C, 1'b1);
    queue_frame(4'd8, {crr_pkg::PCI_CF, 4'd1}, 8'h3C, 1'b0);   // now idle again
    queue_frame(4'd8, {crr_pkg::PCI_FF, 4'h0},
                8'(crr_pkg::BUFFER_BYTES_DEF), 1'b1);          // full buffer
    queue_frame(4'd8, {crr_pkg::PCI_CF, 4'd1}, 8'($urandom), 1'b1);
    queue_frame(4'd8, {crr_pkg::PCI_CF, 4'd2}, 8'($urandom), 1'b1);
    queue_frame(4'd8, {crr_pkg::PCI_FF, 4'hF}, 8'hFF, 1'b1);   // overflow mid-message
    queue_frame(4'd8, {crr_pkg::PCI_SF, 4'd5}, 8'($urandom), 1'b1);  // SF mid-message
    for (int s = 3; s <= 9; s++)
      queue_frame(4'd8, {crr_pkg::PCI_CF, 4'(s)}, 8'($urandom), 1'b1);

    // random traffic, mostly well-formed messages
    while (frames_pending.size() < TOTAL_FRAMES) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        sel = $urandom_range(9);
        if (sel == 0) total = crr_pkg::BUFFER_BYTES_DEF;
        else if (sel < 4) total = $urandom_range(7, crr_pkg::BUFFER_BYTES_DEF - 1);
        else total = $urandom_range(0, 12);
        queue_frame(pick_len(), {crr_pkg::PCI_FF, 4'(total >> 8)}, 8'(total), 1'b1);
        ncf = (total <= crr_pkg::FF_DATA_BYTES) ? 1 : total / crr_pkg::CF_DATA_BYTES;
        for (int s = 1; s <= ncf; s++) begin
          if ($urandom_range(99) < 8) queue_noise();
          roll = $urandom_range(99);
          if (roll < 3) begin  // wrong sequence nibble
            queue_frame(pick_len(),
                        {crr_pkg::PCI_CF, 4'(s) + 4'($urandom_range(1, 15))},
                        8'($urandom), 1'b1);
            break;
          end
          if (roll < 5) break;  // abandoned; next FF restarts reassembly
          queue_frame(pick_len(), {crr_pkg::PCI_CF, 4'(s)}, 8'($urandom), 1'b1);
        end
      end else if (roll < 78) begin
        low = 4'($urandom);
        queue_frame(pick_len(), {crr_pkg::PCI_SF, low}, 8'($urandom),
                    low >= 4'd1 && low <= crr_pkg::SF_MAX_LEN);
      end else if (roll < 88) begin
        queue_frame(pick_len(), {crr_pkg::PCI_CF, 4'($urandom)}, 8'($urandom), 1'b0);
      end else begin
        queue_noise();
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (frames_pending.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_words.size() != 0) begin
      $display("%0d predicted words never arrived", expected_words.size());
      errors += expected_words.size();
    end

    $display("frames taken %0d (%0d of them acted on), result words checked %0d, errors %0d",
             frames_taken, live_frames, words_checked, errors);
    $display("messages delivered %0d, flow-control words %0d (%0d overflow)",
             msgs_done, flow_words, overflow_words);
    if (errors == 0) begin
      $display("can_transport_receive_reassembler_tb OK");
    end else begin
      $display("can_transport_receive_reassembler_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
